>>> sv/cct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cct_pkg
// Shared types, codes and calendar helpers for the calendar clock tick block.
// ----------------------------------------------------------------------------
package cct_pkg;

    // Operation codes carried in the operation field
    typedef enum logic {
        OP_TICK = 1'b0,
        OP_SET  = 1'b1
    } op_t;

    // Hour form codes, for the set hour and for the displayed hour
    typedef enum logic [1:0] {
        HALF_24 = 2'd0,
        HALF_AM = 2'd1,
        HALF_PM = 2'd2,
        HALF_RSV = 2'd3
    } half_t;

    // Count limits
    localparam logic [5:0] LAST_SECOND  = 6'd59;
    localparam logic [5:0] LAST_MINUTE  = 6'd59;
    localparam logic [4:0] LAST_HOUR    = 5'd23;
    localparam logic [4:0] NOON_HOUR    = 5'd12;
    localparam logic [3:0] LAST_MONTH   = 4'd12;
    localparam logic [6:0] LAST_YEAR    = 7'd99;
    localparam logic [2:0] LAST_WEEKDAY = 3'd6;

    // Reset values: midnight, Saturday 1 January 2000
    localparam logic [4:0] RESET_DATE    = 5'd1;
    localparam logic [3:0] RESET_MONTH   = 4'd1;
    localparam logic [2:0] RESET_WEEKDAY = 3'd5;

    // One input beat
    typedef struct packed {
        logic       operation;
        logic [4:0] set_hour;
        logic [1:0] set_hour_half;
        logic [5:0] set_minute;
        logic [4:0] set_day_of_month;
        logic [3:0] set_month;
        logic [6:0] set_year;
        logic [2:0] set_weekday;
    } item_t;

    // Time and date, hour kept in 24-hour form
    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] date;
        logic [3:0] month;
        logic [6:0] year;
        logic [2:0] weekday;
    } cal_t;

    // Length of a month; February has 29 days when the year is a multiple of four
    function automatic logic [4:0] month_days(input logic [3:0] month, input logic [6:0] year);
        logic [4:0] days;
        case (month)
            4'd2: begin
                days = (year[1:0] == 2'd0) ? 5'd29 : 5'd28;
            end
            4'd4, 4'd6, 4'd9, 4'd11: begin
                days = 5'd30;
            end
            default: begin
                days = 5'd31;
            end
        endcase
        return days;
    endfunction

endpackage

>>> sv/cct_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cct_in_reg
// Input register: captures one beat and holds it until the next stage takes it.
// ----------------------------------------------------------------------------
module cct_in_reg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  cct_pkg::item_t s_item,
    input  logic          advance,
    output logic          valid_reg,
    output cct_pkg::item_t item_reg
);

    logic valid_next;

    // Take a new beat whenever the held one leaves or the stage is empty
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Hold payload until replaced
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

>>> sv/cct_calendar.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cct_calendar
// Time and date counters: ripple a one-second tick or load a normalized set.
// ----------------------------------------------------------------------------
module cct_calendar (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           fire,
    input  cct_pkg::item_t item,
    output cct_pkg::cal_t  cal_next
);

    cct_pkg::cal_t cal_reg;
    cct_pkg::cal_t tick_cal;
    cct_pkg::cal_t set_cal;
    logic          sec_wrap;
    logic          min_wrap;
    logic          hour_wrap;
    logic          day_wrap;
    logic          month_wrap;
    logic [4:0]    set_hour_conv;

    // Carry chain for one tick
    always_comb begin
        sec_wrap   = (cal_reg.second == cct_pkg::LAST_SECOND);
        min_wrap   = sec_wrap && (cal_reg.minute == cct_pkg::LAST_MINUTE);
        hour_wrap  = min_wrap && (cal_reg.hour == cct_pkg::LAST_HOUR);
        day_wrap   = hour_wrap &&
                     (cal_reg.date >= cct_pkg::month_days(cal_reg.month, cal_reg.year));
        month_wrap = day_wrap && (cal_reg.month >= cct_pkg::LAST_MONTH);

        tick_cal = cal_reg;
        tick_cal.second = sec_wrap ? 6'd0 : cal_reg.second + 6'd1;
        if (sec_wrap) begin
            tick_cal.minute = min_wrap ? 6'd0 : cal_reg.minute + 6'd1;
        end
        if (min_wrap) begin
            tick_cal.hour = hour_wrap ? 5'd0 : cal_reg.hour + 5'd1;
        end
        if (hour_wrap) begin
            tick_cal.date    = day_wrap ? 5'd1 : cal_reg.date + 5'd1;
            tick_cal.weekday = (cal_reg.weekday >= cct_pkg::LAST_WEEKDAY) ?
                               3'd0 : cal_reg.weekday + 3'd1;
        end
        if (day_wrap) begin
            tick_cal.month = month_wrap ? 4'd1 : cal_reg.month + 4'd1;
        end
        if (month_wrap) begin
            tick_cal.year = (cal_reg.year >= cct_pkg::LAST_YEAR) ? 7'd0 : cal_reg.year + 7'd1;
        end
    end

    // Normalize a set beat: 12-hour to 24-hour, then clamp every field
    always_comb begin
        set_hour_conv = item.set_hour;
        if (item.set_hour_half == cct_pkg::HALF_AM && item.set_hour == cct_pkg::NOON_HOUR) begin
            set_hour_conv = 5'd0;
        end else if (item.set_hour_half == cct_pkg::HALF_PM &&
                     item.set_hour < cct_pkg::NOON_HOUR) begin
            set_hour_conv = item.set_hour + cct_pkg::NOON_HOUR;
        end

        set_cal.second  = 6'd0;
        set_cal.minute  = (item.set_minute > cct_pkg::LAST_MINUTE) ?
                          cct_pkg::LAST_MINUTE : item.set_minute;
        set_cal.hour    = (set_hour_conv > cct_pkg::LAST_HOUR) ?
                          cct_pkg::LAST_HOUR : set_hour_conv;
        set_cal.date    = (item.set_day_of_month == 5'd0) ? 5'd1 : item.set_day_of_month;
        set_cal.month   = (item.set_month == 4'd0) ? 4'd1 :
                          (item.set_month > cct_pkg::LAST_MONTH) ?
                          cct_pkg::LAST_MONTH : item.set_month;
        set_cal.year    = (item.set_year > cct_pkg::LAST_YEAR) ?
                          cct_pkg::LAST_YEAR : item.set_year;
        set_cal.weekday = (item.set_weekday > cct_pkg::LAST_WEEKDAY) ?
                          cct_pkg::LAST_WEEKDAY : item.set_weekday;
    end

    assign cal_next = (item.operation == cct_pkg::OP_SET) ? set_cal : tick_cal;

    // Advance the counters once per beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg.second  <= 6'd0;
            cal_reg.minute  <= 6'd0;
            cal_reg.hour    <= 5'd0;
            cal_reg.date    <= cct_pkg::RESET_DATE;
            cal_reg.month   <= cct_pkg::RESET_MONTH;
            cal_reg.year    <= 7'd0;
            cal_reg.weekday <= cct_pkg::RESET_WEEKDAY;
        end else if (fire) begin
            cal_reg <= cal_next;
        end
    end

    // Counters stay within their ranges
    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cal_reg.second <= cct_pkg::LAST_SECOND && cal_reg.minute <= cct_pkg::LAST_MINUTE &&
        cal_reg.hour <= cct_pkg::LAST_HOUR)
        else $error("time counter out of range");

    a_date_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cal_reg.month >= 4'd1 && cal_reg.month <= cct_pkg::LAST_MONTH &&
        cal_reg.date >= 5'd1 && cal_reg.weekday <= cct_pkg::LAST_WEEKDAY &&
        cal_reg.year <= cct_pkg::LAST_YEAR)
        else $error("date counter out of range");

    // A tick without a seconds carry moves only the seconds
    a_tick_no_carry: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && item.operation == cct_pkg::OP_TICK && cal_reg.second != cct_pkg::LAST_SECOND)
        |=> (cal_reg.second == $past(cal_reg.second) + 6'd1) &&
            (cal_reg.minute == $past(cal_reg.minute)) && (cal_reg.date == $past(cal_reg.date)))
        else $error("tick disturbed more than the seconds");

    // A set always clears the seconds
    a_set_clears_sec: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && item.operation == cct_pkg::OP_SET) |=> cal_reg.second == 6'd0)
        else $error("set left seconds nonzero");

endmodule

>>> sv/cct_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cct_out_reg
// Result register: formats the hour for display and holds the result beat.
// ----------------------------------------------------------------------------
module cct_out_reg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          advance,
    input  cct_pkg::cal_t cal_next,
    input  logic          time_mode,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [5:0]    m_seconds,
    output logic [5:0]    m_minutes,
    output logic [4:0]    m_display_hour,
    output logic [1:0]    m_hour_half,
    output logic [4:0]    m_day_of_month,
    output logic [3:0]    m_month_number,
    output logic [6:0]    m_year_of_century,
    output logic [2:0]    m_weekday,
    output logic          m_top_of_hour
);

    logic          valid_reg;
    logic          valid_next;
    cct_pkg::cal_t cal_reg;
    logic [4:0]    shown_next;
    logic [4:0]    shown_reg;
    cct_pkg::half_t half_next;
    cct_pkg::half_t half_reg;

    // Register is free when empty or its beat is taken this cycle
    assign advance = !valid_reg || m_ready;

    // Hour display conversion
    always_comb begin
        shown_next = cal_next.hour;
        half_next  = cct_pkg::HALF_24;
        if (time_mode) begin
            if (cal_next.hour >= cct_pkg::NOON_HOUR) begin
                half_next = cct_pkg::HALF_PM;
                if (cal_next.hour > cct_pkg::NOON_HOUR) begin
                    shown_next = cal_next.hour - cct_pkg::NOON_HOUR;
                end
            end else begin
                half_next = cct_pkg::HALF_AM;
                if (cal_next.hour == 5'd0) begin
                    shown_next = cct_pkg::NOON_HOUR;
                end
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Load result payload
    always_ff @(posedge aclk) begin
        if (in_valid && advance) begin
            cal_reg   <= cal_next;
            shown_reg <= shown_next;
            half_reg  <= half_next;
        end
    end

    assign m_valid           = valid_reg;
    assign m_seconds         = cal_reg.second;
    assign m_minutes         = cal_reg.minute;
    assign m_display_hour    = shown_reg;
    assign m_hour_half       = half_reg;
    assign m_day_of_month    = cal_reg.date;
    assign m_month_number    = cal_reg.month;
    assign m_year_of_century = cal_reg.year;
    assign m_weekday         = cal_reg.weekday;
    assign m_top_of_hour     = (cal_reg.second == 6'd0) && (cal_reg.minute == 6'd0);

endmodule

>>> sv/calendar_clock_tick.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_clock_tick
// Real-time-clock calendar counter with two-digit year and 12/24-hour display.
// ----------------------------------------------------------------------------
// Each input beat is either a one-second tick or a set of time and date, and
// produces exactly one result beat with the full time and date after it. The
// block takes one beat per clock cycle while m_ready does not hold it back. A
// beat goes through an input register and then a result register, and its
// result is valid once it has been loaded into the result register. The
// counters update in the cycle the beat passes from one register to the next,
// so back-to-back beats see each other's effect. A result that waits for
// m_ready holds the input register, which, while it holds a beat, keeps
// s_ready low. The hour format register is written through cfg_wr_en/cfg_wr_data
// and should change only while idle.
// After reset the clock reads 00:00:00, Saturday 1 January 2000, 24-hour form.
// ----------------------------------------------------------------------------
module calendar_clock_tick (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_operation,
    input  logic [4:0] s_set_hour,
    input  logic [1:0] s_set_hour_half,
    input  logic [5:0] s_set_minute,
    input  logic [4:0] s_set_day_of_month,
    input  logic [3:0] s_set_month,
    input  logic [6:0] s_set_year,
    input  logic [2:0] s_set_weekday,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [5:0] m_seconds,
    output logic [5:0] m_minutes,
    output logic [4:0] m_display_hour,
    output logic [1:0] m_hour_half,
    output logic [4:0] m_day_of_month,
    output logic [3:0] m_month_number,
    output logic [6:0] m_year_of_century,
    output logic [2:0] m_weekday,
    output logic       m_top_of_hour
);

    cct_pkg::item_t s_item;
    cct_pkg::item_t item_reg;
    cct_pkg::cal_t  cal_next;
    logic           in_valid_reg;
    logic           advance;
    logic           time_mode_reg;

    // Hour format register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            time_mode_reg <= cfg_wr_data;
        end
    end

    // Gather input beat
    always_comb begin
        s_item.operation        = s_operation;
        s_item.set_hour         = s_set_hour;
        s_item.set_hour_half    = s_set_hour_half;
        s_item.set_minute       = s_set_minute;
        s_item.set_day_of_month = s_set_day_of_month;
        s_item.set_month        = s_set_month;
        s_item.set_year         = s_set_year;
        s_item.set_weekday      = s_set_weekday;
    end

    cct_in_reg u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .advance   (advance),
        .valid_reg (in_valid_reg),
        .item_reg  (item_reg)
    );

    cct_calendar u_calendar (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (in_valid_reg && advance),
        .item     (item_reg),
        .cal_next (cal_next)
    );

    cct_out_reg u_out_reg (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .in_valid          (in_valid_reg),
        .advance           (advance),
        .cal_next          (cal_next),
        .time_mode         (time_mode_reg),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_seconds         (m_seconds),
        .m_minutes         (m_minutes),
        .m_display_hour    (m_display_hour),
        .m_hour_half       (m_hour_half),
        .m_day_of_month    (m_day_of_month),
        .m_month_number    (m_month_number),
        .m_year_of_century (m_year_of_century),
        .m_weekday         (m_weekday),
        .m_top_of_hour     (m_top_of_hour)
    );

endmodule

>>> tb/calendar_clock_tick_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_clock_tick_tb
// Self-checking bench for the calendar clock tick block.
// ----------------------------------------------------------------------------
// A local calendar model keeps its own copy of the time, date and hour format.
// Every accepted input beat is run through it, and the resulting reading is
// queued. Each result beat is then compared, field by field, with the oldest
// queued reading. The stimulus covers set-field clamping and hour forms, both
// display formats, month, year and weekday rollovers, and a long random run
// built mostly from set-then-tick sequences that cross hour and day boundaries.
// The sender idles in random bursts and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module calendar_clock_tick_tb;

    // One result beat as the model expects it
    typedef struct packed {
        logic [5:0]      seconds;
        logic [5:0]      minutes;
        logic [4:0]      display_hour;
        cct_pkg::half_t  hour_half;
        logic [4:0]      day_of_month;
        logic [3:0]      month_number;
        logic [6:0]      year_of_century;
        logic [2:0]      weekday;
        logic            top_of_hour;
    } reading_t;

    typedef enum int {
        RX_FREE,
        RX_COIN,
        RX_STARVED,
        RX_PERIODIC
    } rx_pattern_t;

    localparam int RANDOM_ITEMS = 1100;

    logic       aclk;
    logic       aresetn;
    logic       cfg_wr_en;
    logic       cfg_wr_data;
    logic       s_valid;
    logic       s_ready;
    logic       s_operation;
    logic [4:0] s_set_hour;
    logic [1:0] s_set_hour_half;
    logic [5:0] s_set_minute;
    logic [4:0] s_set_day_of_month;
    logic [3:0] s_set_month;
    logic [6:0] s_set_year;
    logic [2:0] s_set_weekday;
    logic       m_valid;
    logic       m_ready;
    logic [5:0] m_seconds;
    logic [5:0] m_minutes;
    logic [4:0] m_display_hour;
    logic [1:0] m_hour_half;
    logic [4:0] m_day_of_month;
    logic [3:0] m_month_number;
    logic [6:0] m_year_of_century;
    logic [2:0] m_weekday;
    logic       m_top_of_hour;

    // Calendar model state
    cct_pkg::cal_t clock_now;
    bit            hour12_mode;
    reading_t      readings_due[$];

    int          mismatch_count;
    int          items_sent;
    int          burst_left;
    rx_pattern_t rx_pattern;
    int          rx_left;
    int          rx_phase;

    calendar_clock_tick dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_set_hour        (s_set_hour),
        .s_set_hour_half   (s_set_hour_half),
        .s_set_minute      (s_set_minute),
        .s_set_day_of_month(s_set_day_of_month),
        .s_set_month       (s_set_month),
        .s_set_year        (s_set_year),
        .s_set_weekday     (s_set_weekday),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_seconds         (m_seconds),
        .m_minutes         (m_minutes),
        .m_display_hour    (m_display_hour),
        .m_hour_half       (m_hour_half),
        .m_day_of_month    (m_day_of_month),
        .m_month_number    (m_month_number),
        .m_year_of_century (m_year_of_century),
        .m_weekday         (m_weekday),
        .m_top_of_hour     (m_top_of_hour)
    );

    // 100 MHz clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Calendar model
    // ------------------------------------------------------------------------

    function automatic int days_in(input int month, input int year);
        int n;
        if (month == 2) begin
            n = (year % 4 == 0) ? 29 : 28;
        end else if (month == 4 || month == 6 || month == 9 || month == 11) begin
            n = 30;
        end else begin
            n = 31;
        end
        return n;
    endfunction

    // Advance one second and ripple the carry up to the weekday
    function automatic void tick_calendar();
        if (clock_now.second < cct_pkg::LAST_SECOND) begin
            clock_now.second = clock_now.second + 6'd1;
            return;
        end
        clock_now.second = '0;
        if (clock_now.minute < cct_pkg::LAST_MINUTE) begin
            clock_now.minute = clock_now.minute + 6'd1;
            return;
        end
        clock_now.minute = '0;
        if (clock_now.hour < cct_pkg::LAST_HOUR) begin
            clock_now.hour = clock_now.hour + 5'd1;
            return;
        end
        clock_now.hour = '0;
        // days past the month length also roll over
        if (int'(clock_now.date) >= days_in(clock_now.month, clock_now.year)) begin
            clock_now.date  = 5'd1;
            clock_now.month = clock_now.month + 4'd1;
        end else begin
            clock_now.date = clock_now.date + 5'd1;
        end
        if (clock_now.month > cct_pkg::LAST_MONTH) begin
            clock_now.month = 4'd1;
            clock_now.year  = (clock_now.year >= cct_pkg::LAST_YEAR) ?
                              7'd0 : clock_now.year + 7'd1;
        end
        clock_now.weekday = (clock_now.weekday >= cct_pkg::LAST_WEEKDAY) ?
                            3'd0 : clock_now.weekday + 3'd1;
    endfunction

    // Load time and date, normalize the hour and clamp each field
    function automatic void load_calendar(input cct_pkg::item_t it);
        int h;
        h = it.set_hour;
        if (it.set_hour_half == cct_pkg::HALF_AM && h == 12) begin
            h = 0;
        end else if (it.set_hour_half == cct_pkg::HALF_PM && h < 12) begin
            h = h + 12;
        end
        if (h > 23) h = 23;
        clock_now.hour    = 5'(h);
        clock_now.minute  = (it.set_minute > cct_pkg::LAST_MINUTE) ?
                            cct_pkg::LAST_MINUTE : it.set_minute;
        clock_now.second  = '0;
        clock_now.date    = (it.set_day_of_month == 5'd0) ? 5'd1 : it.set_day_of_month;
        clock_now.month   = (it.set_month == 4'd0) ? 4'd1 :
                            (it.set_month > cct_pkg::LAST_MONTH) ?
                            cct_pkg::LAST_MONTH : it.set_month;
        clock_now.year    = (it.set_year > cct_pkg::LAST_YEAR) ?
                            cct_pkg::LAST_YEAR : it.set_year;
        clock_now.weekday = (it.set_weekday > cct_pkg::LAST_WEEKDAY) ?
                            cct_pkg::LAST_WEEKDAY : it.set_weekday;
    endfunction

    // Apply one beat and return the reading it should produce
    function automatic reading_t step_calendar(input cct_pkg::item_t it);
        reading_t r;
        if (cct_pkg::op_t'(it.operation) == cct_pkg::OP_SET) begin
            load_calendar(it);
        end else begin
            tick_calendar();
        end
        r.display_hour = clock_now.hour;
        r.hour_half    = cct_pkg::HALF_24;
        if (hour12_mode) begin
            if (clock_now.hour >= cct_pkg::NOON_HOUR) begin
                r.hour_half = cct_pkg::HALF_PM;
                if (clock_now.hour > cct_pkg::NOON_HOUR) begin
                    r.display_hour = clock_now.hour - cct_pkg::NOON_HOUR;
                end
            end else begin
                r.hour_half = cct_pkg::HALF_AM;
                if (clock_now.hour == 5'd0) r.display_hour = cct_pkg::NOON_HOUR;
            end
        end
        r.seconds         = clock_now.second;
        r.minutes         = clock_now.minute;
        r.day_of_month    = clock_now.date;
        r.month_number    = clock_now.month;
        r.year_of_century = clock_now.year;
        r.weekday         = clock_now.weekday;
        r.top_of_hour     = (clock_now.second == 6'd0 && clock_now.minute == 6'd0);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Beat builders
    // ------------------------------------------------------------------------

    function automatic cct_pkg::item_t make_set(input int h, input cct_pkg::half_t half,
                                                input int mi, input int d, input int mo,
                                                input int y, input int wd);
        cct_pkg::item_t it;
        it.operation        = cct_pkg::OP_SET;
        it.set_hour         = 5'(h);
        it.set_hour_half    = half;
        it.set_minute       = 6'(mi);
        it.set_day_of_month = 5'(d);
        it.set_month        = 4'(mo);
        it.set_year         = 7'(y);
        it.set_weekday      = 3'(wd);
        return it;
    endfunction

    // Any set fields at all, out-of-range codes included
    function automatic cct_pkg::item_t make_wild_set();
        return make_set($urandom_range(0, 31), cct_pkg::half_t'($urandom_range(0, 3)),
                        $urandom_range(0, 63), $urandom_range(0, 31),
                        $urandom_range(0, 15), $urandom_range(0, 127),
                        $urandom_range(0, 7));
    endfunction

    // Tick with junk in the set fields, which the block must ignore
    function automatic cct_pkg::item_t make_tick();
        cct_pkg::item_t it;
        it           = make_wild_set();
        it.operation = cct_pkg::OP_TICK;
        return it;
    endfunction

    // Express a 24-hour value in a random one of the legal input forms
    function automatic void hour_in_form(input int h24, output int h,
                                         output cct_pkg::half_t half);
        int form;
        form = $urandom_range(0, 2);
        if (form == 0) begin
            h    = h24;
            half = cct_pkg::HALF_24;
        end else if (h24 < 12) begin
            h    = (h24 == 0) ? 12 : h24;
            half = cct_pkg::HALF_AM;
        end else begin
            h    = (h24 == 12) ? 12 : h24 - 12;
            half = cct_pkg::HALF_PM;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Sender, drain and register write
    // ------------------------------------------------------------------------

    // Send one beat, with a random gap at the start of each burst
    task automatic send_item(input cct_pkg::item_t it);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end
        burst_left--;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid            = 1'b1;
        s_operation        = it.operation;
        s_set_hour         = it.set_hour;
        s_set_hour_half    = it.set_hour_half;
        s_set_minute       = it.set_minute;
        s_set_day_of_month = it.set_day_of_month;
        s_set_month        = it.set_month;
        s_set_year         = it.set_year;
        s_set_weekday      = it.set_weekday;
        do @(posedge aclk); while (!s_ready);
        readings_due.push_back(step_calendar(it));
        items_sent++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(make_tick());
    endtask

    // Hold the sender until every reading has come back, then let the pipe settle
    task automatic wait_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (readings_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_time_mode(input bit mode);
        wait_drained();
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = mode;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
        hour12_mode = mode;
    endtask

    // Load 23:59 on the given date and tick the given number of seconds
    task automatic run_from_late_evening(input int d, input int mo, input int y, input int wd,
                                         input int n_ticks);
        int             h;
        cct_pkg::half_t half;
        hour_in_form(23, h, half);
        send_item(make_set(h, half, 59, d, mo, y, wd));
        send_ticks(n_ticks);
    endtask

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("%0t: %s got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : check_results
        reading_t want;
        if (aresetn && m_valid && m_ready) begin
            if (readings_due.size() == 0) begin
                flag_mismatch("unexpected result beat, queued readings", 0, 1);
            end else begin
                want = readings_due.pop_front();
                if (m_seconds !== want.seconds)
                    flag_mismatch("seconds", m_seconds, want.seconds);
                if (m_minutes !== want.minutes)
                    flag_mismatch("minutes", m_minutes, want.minutes);
                if (m_display_hour !== want.display_hour)
                    flag_mismatch("display_hour", m_display_hour, want.display_hour);
                if (m_hour_half !== want.hour_half)
                    flag_mismatch("hour_half", m_hour_half, want.hour_half);
                if (m_day_of_month !== want.day_of_month)
                    flag_mismatch("day_of_month", m_day_of_month, want.day_of_month);
                if (m_month_number !== want.month_number)
                    flag_mismatch("month_number", m_month_number, want.month_number);
                if (m_year_of_century !== want.year_of_century)
                    flag_mismatch("year_of_century", m_year_of_century, want.year_of_century);
                if (m_weekday !== want.weekday)
                    flag_mismatch("weekday", m_weekday, want.weekday);
                if (m_top_of_hour !== want.top_of_hour)
                    flag_mismatch("top_of_hour", m_top_of_hour, want.top_of_hour);
            end
        end
    end

    // Receiver: switch to a randomly chosen stall pattern after each random run length
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_pattern = rx_pattern_t'($urandom_range(0, 3));
            rx_left    = $urandom_range(32, 256);
        end
        rx_left--;
        rx_phase++;
        case (rx_pattern)
            RX_FREE: begin
                m_ready = 1'b1;
            end
            RX_COIN: begin
                m_ready = 1'($urandom_range(0, 1));
            end
            RX_STARVED: begin
                m_ready = ($urandom_range(0, 3) == 0);
            end
            default: begin
                m_ready = (rx_phase % 3 == 0);
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset state, every hour form and the clamping of each set field
    task automatic test_set_forms();
        send_item(make_tick());
        send_item(make_set(0, cct_pkg::HALF_24, 0, 1, 1, 0, 0));
        send_item(make_set(12, cct_pkg::HALF_AM, 30, 15, 6, 50, 3));
        send_item(make_set(11, cct_pkg::HALF_AM, 5, 2, 2, 1, 1));
        send_item(make_set(12, cct_pkg::HALF_PM, 0, 28, 2, 4, 2));
        send_item(make_set(1, cct_pkg::HALF_PM, 59, 31, 12, 99, 6));
        send_item(make_set(11, cct_pkg::HALF_PM, 1, 30, 11, 98, 4));
        send_item(make_set(20, cct_pkg::HALF_AM, 7, 3, 3, 3, 5));
        send_item(make_set(5, cct_pkg::HALF_RSV, 8, 4, 4, 4, 0));
        send_item(make_set(31, cct_pkg::HALF_24, 63, 0, 0, 127, 7));
        send_item(make_set(31, cct_pkg::HALF_PM, 60, 31, 15, 100, 7));
        send_item(make_set(23, cct_pkg::HALF_RSV, 0, 16, 13, 0, 6));
        // tick with every set field at all ones
        send_item('{operation: cct_pkg::OP_TICK, set_hour: 5'h1f,
                    set_hour_half: cct_pkg::HALF_RSV,
                    set_minute: 6'h3f, set_day_of_month: 5'h1f, set_month: 4'hf,
                    set_year: 7'h7f, set_weekday: 3'h7});
    endtask

    // 12-hour display around midnight and midday
    task automatic test_twelve_hour_display();
        write_time_mode(1'b1);
        send_item(make_set(0, cct_pkg::HALF_24, 0, 1, 1, 0, 0));
        send_item(make_set(11, cct_pkg::HALF_24, 59, 1, 1, 0, 0));
        send_item(make_set(12, cct_pkg::HALF_AM, 1, 1, 1, 0, 0));
        send_item(make_set(12, cct_pkg::HALF_24, 0, 1, 1, 0, 0));
        send_item(make_set(13, cct_pkg::HALF_24, 0, 1, 1, 0, 0));
        send_item(make_set(23, cct_pkg::HALF_24, 59, 1, 1, 0, 0));
        send_item(make_tick());
    endtask

    // Day, month, year and weekday carries at midnight
    task automatic test_calendar_rollover();
        run_from_late_evening(31, 12, 99, 6, 61);  // century wrap, Sunday to Monday
        run_from_late_evening(28, 2, 4, 2, 60);    // leap February
        run_from_late_evening(29, 2, 8, 3, 60);
        run_from_late_evening(28, 2, 5, 1, 60);    // common February
        run_from_late_evening(31, 2, 1, 0, 60);    // day past month end
        run_from_late_evening(30, 4, 10, 4, 60);
        run_from_late_evening(15, 7, 20, 5, 60);   // plain mid-month carry
    endtask

    // Mostly set-then-tick sequences across hour and day boundaries, some noise
    task automatic test_random_traffic();
        int             phase_end;
        int             pick;
        int             mo;
        int             y;
        int             d;
        int             h;
        cct_pkg::half_t half;
        for (int phase = 0; phase < 4; phase++) begin
            write_time_mode(phase[0]);
            phase_end = items_sent + RANDOM_ITEMS / 4;
            while (items_sent < phase_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    mo = $urandom_range(1, 12);
                    if ($urandom_range(0, 3) == 0) mo = 12;
                    y = ($urandom_range(0, 3) == 0) ? 99 : $urandom_range(0, 99);
                    case ($urandom_range(0, 2))
                        0: d = days_in(mo, y);
                        1: d = days_in(mo, y) - 1;
                        default: d = $urandom_range(1, 31);
                    endcase
                    run_from_late_evening(d, mo, y, $urandom_range(0, 6),
                                          $urandom_range(58, 66));
                end else if (pick < 70) begin
                    hour_in_form($urandom_range(0, 23), h, half);
                    mo = $urandom_range(1, 12);
                    y  = $urandom_range(0, 99);
                    send_item(make_set(h, half, ($urandom_range(0, 1) == 0) ? 59 :
                                       $urandom_range(0, 59),
                                       $urandom_range(1, days_in(mo, y)), mo, y,
                                       $urandom_range(0, 6)));
                    send_ticks($urandom_range(0, 70));
                end else if (pick < 85) begin
                    send_item(make_wild_set());
                    send_ticks($urandom_range(0, 8));
                end else begin
                    repeat ($urandom_range(1, 16)) begin
                        send_item(($urandom_range(0, 1) == 0) ? make_tick() : make_wild_set());
                    end
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        aresetn            = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = 1'b0;
        s_valid            = 1'b0;
        s_operation        = cct_pkg::OP_TICK;
        s_set_hour         = '0;
        s_set_hour_half    = cct_pkg::HALF_24;
        s_set_minute       = '0;
        s_set_day_of_month = '0;
        s_set_month        = '0;
        s_set_year         = '0;
        s_set_weekday      = '0;
        m_ready            = 1'b0;
        rx_pattern         = RX_FREE;
        rx_left            = 0;
        rx_phase           = 0;
        mismatch_count     = 0;
        items_sent         = 0;
        burst_left         = 0;

        // power-on time: midnight, Saturday 1 January 2000, 24-hour display
        hour12_mode       = 1'b0;
        clock_now.second  = '0;
        clock_now.minute  = '0;
        clock_now.hour    = '0;
        clock_now.date    = cct_pkg::RESET_DATE;
        clock_now.month   = cct_pkg::RESET_MONTH;
        clock_now.year    = '0;
        clock_now.weekday = cct_pkg::RESET_WEEKDAY;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_set_forms();
        test_twelve_hour_display();
        test_calendar_rollover();
        test_random_traffic();

        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("calendar_clock_tick: match");
        end else begin
            $display("calendar_clock_tick: mismatch");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("calendar_clock_tick: mismatch");
        $finish;
    end

endmodule

>>> files.f
sv/cct_pkg.sv
sv/cct_in_reg.sv
sv/cct_calendar.sv
sv/cct_out_reg.sv
sv/calendar_clock_tick.sv
tb/calendar_clock_tick_tb.sv
